>>> sv/cau_pkg.sv
// cau_pkg: shared types and defaults for the complex arithmetic unit
// no dependencies; imported by every module of the block
`default_nettype none

package cau_pkg;

  localparam int unsigned CAU_DATA_WIDTH  = 16;
  localparam int unsigned CAU_FRAC_BITS   = 8;
  localparam int unsigned CAU_QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cau_cmd_e;

  // classification handed from the front end to the back end
  typedef struct packed {
    cau_cmd_e cmd;
    logic     dz;
  } cau_ctrl_t;

  localparam int unsigned CAU_CTRL_W = $bits(cau_ctrl_t);

endpackage

`default_nettype wire

>>> sv/complex_arithmetic_unit.sv
// complex_arithmetic_unit: signed fixed-point complex add, sub, mul, div
// usage:
//   s_axis carries one operation per transfer: tuser is the command
//   (add, subtract, multiply, divide), tdata holds a and b.
//   m_axis returns one result per transfer, in the order of acceptance:
//   tdata holds the saturated real and imaginary parts, tuser the flags.
//   path from input transfer to output valid: first front-end stage, which
//   loads on the input transfer, second front-end stage, queue, one setup
//   stage, one divider stage per quotient bit, output register; every
//   command takes the same path, through the fully pipelined divider.
//   throughput: one transfer per cycle while m_axis does not stall.
//   a stalled m_axis freezes the back-end pipeline; the front end keeps
//   accepting until its two stages and the queue of QUEUE_DEPTH entries
//   are full, and only then drops s_axis_tready.
//   reset clears all valid state; no operation is in flight afterwards.
//   divide with b equal to zero gives zero and the divide-by-zero flag.
// depends on cau_pkg, cau_front, cau_fifo, cau_back
`default_nettype none

module complex_arithmetic_unit
  import cau_pkg::*;
#(
  parameter int unsigned DATA_WIDTH  = CAU_DATA_WIDTH,
  parameter int unsigned FRAC_BITS   = CAU_FRAC_BITS,
  parameter int unsigned QUEUE_DEPTH = CAU_QUEUE_DEPTH,
  localparam int unsigned IN_DW      = ((4 * DATA_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_DW     = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // a_real, a_imag, b_real, b_imag
  input  wire logic [IN_DW-1:0]  s_axis_tdata,
  // command
  input  wire logic [1:0]        s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // result_real, result_imag
  output logic [OUT_DW-1:0]      m_axis_tdata,
  // overflow, divide_by_zero
  output logic [1:0]             m_axis_tuser
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned QW = CAU_CTRL_W + 2 * SW + PW;

  logic                 fe_valid, fe_ready;
  cau_ctrl_t            fe_ctrl;
  logic signed [SW-1:0] fe_re, fe_im;
  logic [PW-1:0]        fe_den;

  logic                 q_valid, q_ready;
  logic [QW-1:0]        q_data;
  cau_ctrl_t            q_ctrl;
  logic [SW-1:0]        q_re, q_im;
  logic [PW-1:0]        q_den;

  logic [W-1:0]         res_re, res_im;
  logic                 res_ovf, res_dz;

  cau_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (cau_cmd_e'(s_axis_tuser)),
    .in_ar_i     (s_axis_tdata[W-1:0]),
    .in_ai_i     (s_axis_tdata[2*W-1:W]),
    .in_br_i     (s_axis_tdata[3*W-1:2*W]),
    .in_bi_i     (s_axis_tdata[4*W-1:3*W]),
    .out_valid_o (fe_valid),
    .out_ready_i (fe_ready),
    .out_ctrl_o  (fe_ctrl),
    .out_re_o    (fe_re),
    .out_im_o    (fe_im),
    .out_den_o   (fe_den)
  );

  cau_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fe_valid),
    .in_ready_o  (fe_ready),
    .in_data_i   ({fe_ctrl, fe_re, fe_im, fe_den}),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_data)
  );

  assign q_ctrl = cau_ctrl_t'(q_data[QW-1 -: CAU_CTRL_W]);
  assign q_re   = q_data[PW+2*SW-1 -: SW];
  assign q_im   = q_data[PW+SW-1 -: SW];
  assign q_den  = q_data[PW-1:0];

  cau_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_ctrl_i   (q_ctrl),
    .in_re_i     ($signed(q_re)),
    .in_im_i     ($signed(q_im)),
    .in_den_i    (q_den),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_re_o    (res_re),
    .out_im_o    (res_im),
    .out_ovf_o   (res_ovf),
    .out_dz_o    (res_dz)
  );

  assign m_axis_tdata = OUT_DW'({res_im, res_re});
  assign m_axis_tuser = {res_dz, res_ovf};

  a_dz_result_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> (m_axis_tdata == '0) && !m_axis_tuser[0])
    else $error("divide-by-zero result carries nonzero data or overflow");

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> !fe_ready && fe_valid)
    else $error("input stalled while the queue still had room");

  a_queue_holds_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid && !q_ready |=> q_valid && $stable(q_data))
    else $error("queue head changed while the back end was stalled");

endmodule

`default_nettype wire

>>> sv/cau_fifo.sv
// cau_fifo: small flop-based queue between front end and back end
// depends on cau_pkg for the default depth
`default_nettype none

module cau_fifo
  import cau_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = CAU_QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [WIDTH-1:0] in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [WIDTH-1:0]      out_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             push, pop;

  assign in_ready_o  = (cnt_q != CW'(DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

`default_nettype wire

>>> sv/cau_front.sv
// cau_front: accepts operand transfers, forms products, sums and |b|^2
// and classifies the command; depends on cau_pkg
`default_nettype none

module cau_front
  import cau_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = CAU_DATA_WIDTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire cau_cmd_e                     in_cmd_i,
  input  wire logic signed [DATA_WIDTH-1:0] in_ar_i,
  input  wire logic signed [DATA_WIDTH-1:0] in_ai_i,
  input  wire logic signed [DATA_WIDTH-1:0] in_br_i,
  input  wire logic signed [DATA_WIDTH-1:0] in_bi_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output cau_ctrl_t                         out_ctrl_o,
  output logic signed [2*DATA_WIDTH:0]      out_re_o,
  output logic signed [2*DATA_WIDTH:0]      out_im_o,
  output logic [2*DATA_WIDTH-1:0]           out_den_o
);

  localparam int unsigned PW = 2 * DATA_WIDTH;
  localparam int unsigned SW = PW + 1;

  // stage 1: multipliers and short sums
  logic                    v1_q;
  cau_cmd_e                cmd1_q;
  logic signed [PW-1:0]    p_rr_q, p_ii_q, p_ir_q, p_ri_q, p_bbr_q, p_bbi_q;
  logic signed [DATA_WIDTH:0] sum_re_q, sum_im_q;

  // stage 2: combined parts and classification
  logic                    v2_q;
  cau_ctrl_t               ctrl2_q, ctrl2_d;
  logic signed [SW-1:0]    re2_q, re2_d, im2_q, im2_d;
  logic [PW-1:0]           den2_q, den2_d;

  logic                    rdy1, rdy2;
  logic signed [SW-1:0]    rr, ii, ir, ri;

  assign rdy2       = !v2_q || out_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  assign rr = {p_rr_q[PW-1], p_rr_q};
  assign ii = {p_ii_q[PW-1], p_ii_q};
  assign ir = {p_ir_q[PW-1], p_ir_q};
  assign ri = {p_ri_q[PW-1], p_ri_q};

  always_comb begin
    re2_d = '0;
    im2_d = '0;
    unique case (cmd1_q)
      CMD_ADD, CMD_SUB: begin
        re2_d = {{DATA_WIDTH{sum_re_q[DATA_WIDTH]}}, sum_re_q};
        im2_d = {{DATA_WIDTH{sum_im_q[DATA_WIDTH]}}, sum_im_q};
      end
      CMD_MUL: begin
        re2_d = rr - ii;
        im2_d = ir + ri;
      end
      CMD_DIV: begin
        re2_d = rr + ii;
        im2_d = ir - ri;
      end
      default: begin
        re2_d = '0;
        im2_d = '0;
      end
    endcase
    den2_d      = $unsigned(p_bbr_q) + $unsigned(p_bbi_q);
    ctrl2_d.cmd = cmd1_q;
    ctrl2_d.dz  = (cmd1_q == CMD_DIV) && (den2_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      cmd1_q   <= in_cmd_i;
      p_rr_q   <= in_ar_i * in_br_i;
      p_ii_q   <= in_ai_i * in_bi_i;
      p_ir_q   <= in_ai_i * in_br_i;
      p_ri_q   <= in_ar_i * in_bi_i;
      p_bbr_q  <= in_br_i * in_br_i;
      p_bbi_q  <= in_bi_i * in_bi_i;
      sum_re_q <= (in_cmd_i == CMD_SUB) ? in_ar_i - in_br_i : in_ar_i + in_br_i;
      sum_im_q <= (in_cmd_i == CMD_SUB) ? in_ai_i - in_bi_i : in_ai_i + in_bi_i;
    end
    if (rdy2 && v1_q) begin
      ctrl2_q <= ctrl2_d;
      re2_q   <= re2_d;
      im2_q   <= im2_d;
      den2_q  <= den2_d;
    end
  end

  assign out_valid_o = v2_q;
  assign out_ctrl_o  = ctrl2_q;
  assign out_re_o    = re2_q;
  assign out_im_o    = im2_q;
  assign out_den_o   = den2_q;

endmodule

`default_nettype wire

>>> sv/cau_back.sv
// cau_back: scaling, pipelined restoring divider, saturation and output register
// depends on cau_pkg
`default_nettype none

module cau_back
  import cau_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = CAU_DATA_WIDTH,
  parameter int unsigned FRAC_BITS  = CAU_FRAC_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire cau_ctrl_t                     in_ctrl_i,
  input  wire logic signed [2*DATA_WIDTH:0]  in_re_i,
  input  wire logic signed [2*DATA_WIDTH:0]  in_im_i,
  input  wire logic [2*DATA_WIDTH-1:0]       in_den_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [DATA_WIDTH-1:0]              out_re_o,
  output logic [DATA_WIDTH-1:0]              out_im_o,
  output logic                               out_ovf_o,
  output logic                               out_dz_o
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned RW = 3 * W + FRAC_BITS;

  localparam logic signed [SW-1:0] MAXV = {{(W + 2){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = {{(W + 2){1'b1}}, {(W - 1){1'b0}}};
  localparam logic [W-1:0] POS_LIM = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] NEG_LIM = {1'b1, {(W - 1){1'b0}}};

  typedef struct packed {
    logic          div;
    logic          neg_re;
    logic          neg_im;
    logic          qovf_re;
    logic          qovf_im;
    logic [RW-1:0] rem_re;
    logic [RW-1:0] rem_im;
    logic [W-1:0]  q_re;
    logic [W-1:0]  q_im;
    logic [PW-1:0] den;
    logic [W-1:0]  res_re;
    logic [W-1:0]  res_im;
    logic          ovf;
    logic          dz;
  } stage_t;

  stage_t       stg_q [W+1];
  stage_t       s0_d;
  logic [W:0]   vld_q;
  logic         en;

  logic         out_valid_q;
  logic [W-1:0] out_re_q, out_re_d, out_im_q, out_im_d;
  logic         out_ovf_q, out_ovf_d, out_dz_q, out_dz_d;

  // signed saturation to W bits, overflow flag in the top bit
  function automatic logic [W:0] sat(input logic signed [SW-1:0] v);
    logic [W:0] r;
    if (v > MAXV) begin
      r = {1'b1, MAXV[W-1:0]};
    end else if (v < MINV) begin
      r = {1'b1, MINV[W-1:0]};
    end else begin
      r = {1'b0, v[W-1:0]};
    end
    return r;
  endfunction

  // one quotient bit for each part
  function automatic stage_t div_step(input stage_t s, input int unsigned bpos);
    stage_t        n;
    logic [RW-1:0] dsh;
    logic [W-1:0]  qbit;
    n    = s;
    dsh  = RW'(s.den) << bpos;
    qbit = W'(1) << bpos;
    if (s.rem_re >= dsh) begin
      n.rem_re = s.rem_re - dsh;
      n.q_re   = s.q_re | qbit;
    end
    if (s.rem_im >= dsh) begin
      n.rem_im = s.rem_im - dsh;
      n.q_im   = s.q_im | qbit;
    end
    return n;
  endfunction

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // entry stage: direct results for add, sub, mul and divide by zero; operand setup for div
  always_comb begin
    logic signed [SW-1:0] sv_re, sv_im;
    logic [SW-1:0]        mag_re, mag_im;
    logic [W:0]           c_re, c_im;
    sv_re = (in_ctrl_i.cmd == CMD_MUL) ? (in_re_i >>> FRAC_BITS) : in_re_i;
    sv_im = (in_ctrl_i.cmd == CMD_MUL) ? (in_im_i >>> FRAC_BITS) : in_im_i;
    c_re  = sat(sv_re);
    c_im  = sat(sv_im);
    mag_re = in_re_i[SW-1] ? -in_re_i : in_re_i;
    mag_im = in_im_i[SW-1] ? -in_im_i : in_im_i;

    s0_d.div     = (in_ctrl_i.cmd == CMD_DIV) && !in_ctrl_i.dz;
    s0_d.neg_re  = in_re_i[SW-1];
    s0_d.neg_im  = in_im_i[SW-1];
    s0_d.rem_re  = RW'(mag_re) << FRAC_BITS;
    s0_d.rem_im  = RW'(mag_im) << FRAC_BITS;
    s0_d.qovf_re = s0_d.rem_re >= (RW'(in_den_i) << W);
    s0_d.qovf_im = s0_d.rem_im >= (RW'(in_den_i) << W);
    s0_d.q_re    = '0;
    s0_d.q_im    = '0;
    s0_d.den     = in_den_i;
    s0_d.dz      = in_ctrl_i.dz;
    if (in_ctrl_i.dz) begin
      s0_d.res_re = '0;
      s0_d.res_im = '0;
      s0_d.ovf    = 1'b0;
    end else begin
      s0_d.res_re = c_re[W-1:0];
      s0_d.res_im = c_im[W-1:0];
      s0_d.ovf    = c_re[W] || c_im[W];
    end
  end

  // exit stage: sign and saturate the quotient, or pass the direct result through
  always_comb begin
    stage_t       f;
    logic [W-1:0] lim_re, lim_im, mq_re, mq_im;
    logic         o_re, o_im;
    f      = stg_q[W];
    lim_re = f.neg_re ? NEG_LIM : POS_LIM;
    lim_im = f.neg_im ? NEG_LIM : POS_LIM;
    o_re   = f.qovf_re || (f.q_re > lim_re);
    o_im   = f.qovf_im || (f.q_im > lim_im);
    mq_re  = o_re ? lim_re : f.q_re;
    mq_im  = o_im ? lim_im : f.q_im;
    if (f.div) begin
      out_re_d  = f.neg_re ? -mq_re : mq_re;
      out_im_d  = f.neg_im ? -mq_im : mq_im;
      out_ovf_d = o_re || o_im;
      out_dz_d  = 1'b0;
    end else begin
      out_re_d  = f.res_re;
      out_im_d  = f.res_im;
      out_ovf_d = f.ovf;
      out_dz_d  = f.dz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[W-1:0], in_valid_i};
      out_valid_q <= vld_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      stg_q[0] <= s0_d;
      for (int unsigned k = 0; k < W; k++) begin
        stg_q[k+1] <= div_step(stg_q[k], W - 1 - k);
      end
      out_re_q  <= out_re_d;
      out_im_q  <= out_im_d;
      out_ovf_q <= out_ovf_d;
      out_dz_q  <= out_dz_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_re_o    = out_re_q;
  assign out_im_o    = out_im_q;
  assign out_ovf_o   = out_ovf_q;
  assign out_dz_o    = out_dz_q;

endmodule

`default_nettype wire
